// ===== sv/ecc_psm_pkg.sv =====
// Shared types and constants for the elliptic-curve point multiplier.
// No dependencies; used by the interfaces, the divider, the top level and the bench.
package ecc_psm_pkg;

   localparam int IO_BITS     = 16;
   localparam int SCALAR_BITS = 16;
   localparam int TERM_AW     = 4;
   localparam int CSR_AW      = 1;

   localparam logic [CSR_AW-1:0]  CSR_PRIME_MODULUS = 1'b0;
   localparam logic [CSR_AW-1:0]  CSR_CURVE_A       = 1'b1;
   localparam logic [IO_BITS-1:0] PRIME_RESET       = 16'd97;
   localparam logic [IO_BITS-1:0] CURVE_A_RESET     = 16'd2;

   typedef enum logic [4:0] {
      S_IDLE, S_RED_A, S_RED_X, S_RED_Y, S_STORE, S_DEN, S_EDIV, S_EMUL, S_EUPD,
      S_EEND, S_D1, S_D2, S_D3, S_A1, S_LAM, S_L2, S_X1, S_X2, S_FX, S_G, S_Y3,
      S_OPEND, S_ARD, S_ALOAD, S_ANEXT, S_DONE
   } state_type;

   typedef enum logic [1:0] {
      STEP_MUL, STEP_DIV, STEP_WAIT
   } step_type;

   typedef struct packed {
      logic start;
      logic long_div;
   } div_ctl_type;

endpackage

// ===== sv/ecc_psm_req_if.sv =====
// Request channel: base point and scalar word.
// Depends on ecc_psm_pkg for the field width.
interface ecc_psm_req_if;
   logic                            valid;
   logic                            ready;
   logic [ecc_psm_pkg::IO_BITS-1:0] base_x;
   logic [ecc_psm_pkg::IO_BITS-1:0] base_y;
   logic [ecc_psm_pkg::IO_BITS-1:0] scalar_k;

   modport source (output valid, base_x, base_y, scalar_k, input ready);
   modport sink (input valid, base_x, base_y, scalar_k, output ready);
endinterface

// ===== sv/ecc_psm_rsp_if.sv =====
// Response channel: resulting point word.
// Depends on ecc_psm_pkg for the field width.
interface ecc_psm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ecc_psm_pkg::IO_BITS-1:0] result_x;
   logic [ecc_psm_pkg::IO_BITS-1:0] result_y;
   logic                            at_infinity;

   modport source (output valid, result_x, result_y, at_infinity, input ready);
   modport sink (input valid, result_x, result_y, at_infinity, output ready);
endinterface

// ===== sv/ecc_psm_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on ecc_psm_pkg for the control struct.
module ecc_psm_div #(
   parameter int FB = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ecc_psm_pkg::div_ctl_type ctl,
   input  logic [2*FB-1:0]          num,
   input  logic [FB-1:0]            den,
   output logic                     done,
   output logic [FB-1:0]            quo,
   output logic [FB-1:0]            rem
);
   localparam int CW = $clog2(2*FB+1);

   logic [2*FB-1:0] sh_ff, sh_in;
   logic [FB-1:0]   rem_ff, rem_in, den_ff, den_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [FB:0]     trial;
   logic            ge;

   always_comb begin
      trial   = {rem_ff, sh_ff[2*FB-1]};
      ge      = (trial >= {1'b0, den_ff});
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         den_in  = den;
         rem_in  = '0;
         busy_in = 1'b1;
         if (ctl.long_div) begin
            sh_in  = num;
            cnt_in = CW'(2*FB);
         end else begin
            sh_in  = {num[FB-1:0], {FB{1'b0}}};
            cnt_in = CW'(FB);
         end
      end else if (busy_ff) begin
         rem_in = ge ? FB'(trial - {1'b0, den_ff}) : trial[FB-1:0];
         sh_in  = {sh_ff[2*FB-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = sh_ff[FB-1:0];
   assign rem  = rem_ff;
endmodule

// ===== sv/ecc_point_scalar_multiply.sv =====
// Scalar multiplication k*P on y^2 = x^3 + a*x + b over a small prime field.
// Depends on ecc_psm_pkg, ecc_psm_req_if, ecc_psm_rsp_if and ecc_psm_div.
//
// Usage:
//   req_if carries one word (base_x, base_y, scalar_k); rsp_if returns one
//   word (result_x, result_y, at_infinity) per request, in order.
//   csr_we/csr_index/csr_wdata write prime_modulus (0) and curve_a (1);
//   write them only while no request is in flight.
//   One request is worked at a time; req_if.ready is high only when idle.
//   Every field product is reduced by the shared divider, which also runs
//   each extended-Euclid step.
//   A doubling costs about 5 products plus one inversion, an addition about
//   3 products plus one inversion; a 16-bit scalar needs up to 15 doublings
//   and 15 additions. A zero scalar or a modulus below two goes straight to
//   the result without any field arithmetic.
//   The result sits in an output register; a new request is taken while it
//   waits, and the next result waits until rsp_if.ready takes the old one.
//   Reset (synchronous, active high) drops any word in flight and restores
//   prime_modulus = 97 and curve_a = 2.
module ecc_point_scalar_multiply #(
   parameter int FIELD_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   ecc_psm_req_if.sink                         req_if,
   ecc_psm_rsp_if.source                       rsp_if,
   input  logic                                csr_we,
   input  logic [ecc_psm_pkg::CSR_AW-1:0]      csr_index,
   input  logic [ecc_psm_pkg::IO_BITS-1:0]     csr_wdata
);
   localparam int FB = FIELD_BITS;
   localparam int TW = FIELD_BITS + 2;
   localparam int IW = ecc_psm_pkg::IO_BITS;
   localparam int NT = ecc_psm_pkg::SCALAR_BITS;
   localparam int AW = ecc_psm_pkg::TERM_AW;

   ecc_psm_pkg::state_type state_ff, state_in;
   ecc_psm_pkg::step_type  step_ff, step_in;
   ecc_psm_pkg::div_ctl_type div_ctl;

   logic [IW-1:0] pcfg_ff, acfg_ff;
   logic [FB-1:0] p_ff, p_in, aa_ff, aa_in;
   logic [IW-1:0] k_ff, k_in, kd_ff, kd_in;
   logic [AW-1:0] i_ff, i_in;
   logic          add_ph_ff, add_ph_in, dbl_ff, dbl_in;
   logic [FB-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic          qinf_ff, qinf_in;
   logic [FB-1:0] accx_ff, accx_in, accy_ff, accy_in;
   logic          accinf_ff, accinf_in;
   logic [FB-1:0] ux_ff, ux_in, uy_ff, uy_in, vx_ff, vx_in, vy_ff, vy_in;
   logic [FB-1:0] wx_ff, wx_in, wy_ff, wy_in;
   logic          winf_ff, winf_in;
   logic [FB-1:0] m_ff, m_in, lam_ff, lam_in, inv_ff, inv_in;
   logic [2*FB-1:0] prod_ff, prod_in;
   logic [FB-1:0] rp_ff, rp_in, rc_ff, rc_in;
   logic signed [TW-1:0] tp_ff, tp_in, tc_ff, tc_in, tq_ff, tq_in;
   logic signed [TW-1:0] q_s, tfix;
   logic [TW-1:0] tpos;

   logic          rsp_valid_ff, rsp_valid_in, rinf_ff, rinf_in;
   logic [IW-1:0] rx_ff, rx_in, ry_ff, ry_in;

   logic [2*FB:0] term_mem [NT];
   logic [2*FB:0] rd_ff;
   logic          mem_we;

   logic          accept, is_mul, mul_done, div_done, ld_out;
   logic [FB-1:0] ma, mb, div_quo, div_rem, pm, rdx, rdy;
   logic [2*FB-1:0] div_num;
   logic          rd_inf;

   function automatic logic [FB-1:0] fadd(input logic [FB-1:0] u, input logic [FB-1:0] v,
                                          input logic [FB-1:0] p);
      logic [FB:0] s;
      s = {1'b0, u} + {1'b0, v};
      return (s >= {1'b0, p}) ? FB'(s - {1'b0, p}) : s[FB-1:0];
   endfunction

   function automatic logic [FB-1:0] fsub(input logic [FB-1:0] u, input logic [FB-1:0] v,
                                          input logic [FB-1:0] p);
      return u - v + ((u < v) ? p : '0);
   endfunction

   assign accept   = req_if.valid && req_if.ready;
   assign pm       = FB'(pcfg_ff);
   assign rd_inf   = rd_ff[2*FB];
   assign rdx      = rd_ff[2*FB-1:FB];
   assign rdy      = rd_ff[FB-1:0];
   assign is_mul   = (state_ff == ecc_psm_pkg::S_RED_A) || (state_ff == ecc_psm_pkg::S_RED_X) ||
                     (state_ff == ecc_psm_pkg::S_RED_Y) || (state_ff == ecc_psm_pkg::S_D1) ||
                     (state_ff == ecc_psm_pkg::S_D2) || (state_ff == ecc_psm_pkg::S_LAM) ||
                     (state_ff == ecc_psm_pkg::S_L2) || (state_ff == ecc_psm_pkg::S_G);
   assign mul_done = is_mul && (step_ff == ecc_psm_pkg::STEP_WAIT) && div_done;
   assign ld_out   = (state_ff == ecc_psm_pkg::S_DONE) && (!rsp_valid_ff || rsp_if.ready);
   assign mem_we   = (state_ff == ecc_psm_pkg::S_STORE);

   always_comb begin
      div_ctl.long_div = is_mul;
      div_ctl.start    = (is_mul && (step_ff == ecc_psm_pkg::STEP_DIV)) ||
                         ((state_ff == ecc_psm_pkg::S_EDIV) &&
                          (step_ff == ecc_psm_pkg::STEP_MUL) && (rc_ff != '0));
      div_num          = is_mul ? prod_ff : (2*FB)'(rp_ff);
   end

   ecc_psm_div #(.FB(FB)) u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (is_mul ? p_ff : rc_ff),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   always_comb begin
      ma = m_ff;
      mb = FB'(1);
      case (state_ff)
         ecc_psm_pkg::S_RED_A: ma = aa_ff;
         ecc_psm_pkg::S_RED_X: ma = ux_ff;
         ecc_psm_pkg::S_RED_Y: ma = uy_ff;
         ecc_psm_pkg::S_D1: begin
            ma = ux_ff;
            mb = ux_ff;
         end
         ecc_psm_pkg::S_D2: mb = FB'(3);
         ecc_psm_pkg::S_LAM: mb = inv_ff;
         ecc_psm_pkg::S_L2: begin
            ma = lam_ff;
            mb = lam_ff;
         end
         ecc_psm_pkg::S_G: mb = lam_ff;
         default: ma = m_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ecc_psm_pkg::S_IDLE:
            if (accept) begin
               if ((pm < FB'(2)) || (req_if.scalar_k == '0)) state_in = ecc_psm_pkg::S_DONE;
               else state_in = ecc_psm_pkg::S_RED_A;
            end
         ecc_psm_pkg::S_RED_A: if (mul_done) state_in = ecc_psm_pkg::S_RED_X;
         ecc_psm_pkg::S_RED_X: if (mul_done) state_in = ecc_psm_pkg::S_RED_Y;
         ecc_psm_pkg::S_RED_Y: if (mul_done) state_in = ecc_psm_pkg::S_STORE;
         ecc_psm_pkg::S_STORE: begin
            if (kd_ff[IW-1:1] != '0) begin
               state_in = qinf_ff ? ecc_psm_pkg::S_STORE : ecc_psm_pkg::S_DEN;
            end else begin
               state_in = (i_ff == '0) ? ecc_psm_pkg::S_DONE : ecc_psm_pkg::S_ARD;
            end
         end
         ecc_psm_pkg::S_DEN: state_in = ecc_psm_pkg::S_EDIV;
         ecc_psm_pkg::S_EDIV: begin
            if ((step_ff == ecc_psm_pkg::STEP_MUL) && (rc_ff == '0)) begin
               state_in = ecc_psm_pkg::S_EEND;
            end else if ((step_ff == ecc_psm_pkg::STEP_WAIT) && div_done) begin
               state_in = ecc_psm_pkg::S_EMUL;
            end
         end
         ecc_psm_pkg::S_EMUL: state_in = ecc_psm_pkg::S_EUPD;
         ecc_psm_pkg::S_EUPD: state_in = ecc_psm_pkg::S_EDIV;
         ecc_psm_pkg::S_EEND: begin
            if (rp_ff != FB'(1)) state_in = ecc_psm_pkg::S_OPEND;
            else state_in = dbl_ff ? ecc_psm_pkg::S_D1 : ecc_psm_pkg::S_A1;
         end
         ecc_psm_pkg::S_D1: if (mul_done) state_in = ecc_psm_pkg::S_D2;
         ecc_psm_pkg::S_D2: if (mul_done) state_in = ecc_psm_pkg::S_D3;
         ecc_psm_pkg::S_D3: state_in = ecc_psm_pkg::S_LAM;
         ecc_psm_pkg::S_A1: state_in = ecc_psm_pkg::S_LAM;
         ecc_psm_pkg::S_LAM: if (mul_done) state_in = ecc_psm_pkg::S_L2;
         ecc_psm_pkg::S_L2: if (mul_done) state_in = ecc_psm_pkg::S_X1;
         ecc_psm_pkg::S_X1: state_in = ecc_psm_pkg::S_X2;
         ecc_psm_pkg::S_X2: state_in = ecc_psm_pkg::S_FX;
         ecc_psm_pkg::S_FX: state_in = ecc_psm_pkg::S_G;
         ecc_psm_pkg::S_G: if (mul_done) state_in = ecc_psm_pkg::S_Y3;
         ecc_psm_pkg::S_Y3: state_in = ecc_psm_pkg::S_OPEND;
         ecc_psm_pkg::S_OPEND:
            state_in = add_ph_ff ? ecc_psm_pkg::S_ANEXT : ecc_psm_pkg::S_STORE;
         ecc_psm_pkg::S_ARD: begin
            if (k_ff[i_ff]) state_in = ecc_psm_pkg::S_ALOAD;
            else if (i_ff == '0) state_in = ecc_psm_pkg::S_DONE;
         end
         ecc_psm_pkg::S_ALOAD:
            state_in = (rd_inf || accinf_ff) ? ecc_psm_pkg::S_ANEXT : ecc_psm_pkg::S_DEN;
         ecc_psm_pkg::S_ANEXT:
            state_in = (i_ff == '0) ? ecc_psm_pkg::S_DONE : ecc_psm_pkg::S_ARD;
         ecc_psm_pkg::S_DONE: if (ld_out) state_in = ecc_psm_pkg::S_IDLE;
         default: state_in = ecc_psm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      p_in = p_ff;       aa_in = aa_ff;     k_in = k_ff;       kd_in = kd_ff;
      i_in = i_ff;       add_ph_in = add_ph_ff;                dbl_in = dbl_ff;
      qx_in = qx_ff;     qy_in = qy_ff;     qinf_in = qinf_ff;
      accx_in = accx_ff; accy_in = accy_ff; accinf_in = accinf_ff;
      ux_in = ux_ff;     uy_in = uy_ff;     vx_in = vx_ff;     vy_in = vy_ff;
      wx_in = wx_ff;     wy_in = wy_ff;     winf_in = winf_ff;
      m_in = m_ff;       lam_in = lam_ff;   inv_in = inv_ff;   prod_in = prod_ff;
      rp_in = rp_ff;     rc_in = rc_ff;     tp_in = tp_ff;     tc_in = tc_ff;
      tq_in = tq_ff;     step_in = step_ff;
      q_s   = TW'(div_quo);
      tfix  = tp_ff + ((tp_ff < 0) ? TW'(p_ff) : TW'(0));
      tpos  = tfix;
      rsp_valid_in = rsp_valid_ff;
      rx_in = rx_ff;     ry_in = ry_ff;     rinf_in = rinf_ff;

      if (rsp_valid_ff && rsp_if.ready) rsp_valid_in = 1'b0;
      if (ld_out) begin
         rsp_valid_in = 1'b1;
         rinf_in      = accinf_ff;
         rx_in        = accinf_ff ? '0 : IW'(accx_ff);
         ry_in        = accinf_ff ? '0 : IW'(accy_ff);
      end

      if (is_mul) begin
         case (step_ff)
            ecc_psm_pkg::STEP_MUL: begin
               prod_in = (2*FB)'(ma) * (2*FB)'(mb);
               step_in = ecc_psm_pkg::STEP_DIV;
            end
            ecc_psm_pkg::STEP_DIV: step_in = ecc_psm_pkg::STEP_WAIT;
            ecc_psm_pkg::STEP_WAIT: if (div_done) step_in = ecc_psm_pkg::STEP_MUL;
            default: step_in = ecc_psm_pkg::STEP_MUL;
         endcase
      end

      case (state_ff)
         ecc_psm_pkg::S_IDLE: begin
            if (accept) begin
               p_in      = pm;
               aa_in     = FB'(acfg_ff);
               ux_in     = FB'(req_if.base_x);
               uy_in     = FB'(req_if.base_y);
               k_in      = req_if.scalar_k;
               kd_in     = req_if.scalar_k;
               i_in      = '0;
               add_ph_in = 1'b0;
               accinf_in = 1'b1;
            end
         end
         ecc_psm_pkg::S_RED_A: if (mul_done) aa_in = div_rem;
         ecc_psm_pkg::S_RED_X: if (mul_done) qx_in = div_rem;
         ecc_psm_pkg::S_RED_Y: begin
            if (mul_done) begin
               qy_in   = div_rem;
               qinf_in = 1'b0;
            end
         end
         ecc_psm_pkg::S_STORE: begin
            if (kd_ff[IW-1:1] != '0) begin
               kd_in  = kd_ff >> 1;
               i_in   = i_ff + AW'(1);
               ux_in  = qx_ff;
               uy_in  = qy_ff;
               vx_in  = qx_ff;
               dbl_in = 1'b1;
            end else begin
               accx_in   = qx_ff;
               accy_in   = qy_ff;
               accinf_in = qinf_ff;
               add_ph_in = 1'b1;
               if (i_ff != '0) i_in = i_ff - AW'(1);
            end
         end
         ecc_psm_pkg::S_DEN: begin
            rp_in = p_ff;
            rc_in = dbl_ff ? fadd(uy_ff, uy_ff, p_ff) : fsub(vx_ff, ux_ff, p_ff);
            tp_in = '0;
            tc_in = TW'(1);
         end
         ecc_psm_pkg::S_EDIV: begin
            if ((step_ff == ecc_psm_pkg::STEP_MUL) && (rc_ff != '0)) begin
               step_in = ecc_psm_pkg::STEP_WAIT;
            end else if ((step_ff == ecc_psm_pkg::STEP_WAIT) && div_done) begin
               step_in = ecc_psm_pkg::STEP_MUL;
            end
         end
         ecc_psm_pkg::S_EMUL: tq_in = tc_ff * q_s;
         ecc_psm_pkg::S_EUPD: begin
            tp_in = tc_ff;
            tc_in = tp_ff - tq_ff;
            rp_in = rc_ff;
            rc_in = div_rem;
         end
         ecc_psm_pkg::S_EEND: begin
            if (rp_ff != FB'(1)) winf_in = 1'b1;
            else inv_in = (tpos >= TW'(p_ff)) ? FB'(tpos - TW'(p_ff)) : FB'(tpos);
         end
         ecc_psm_pkg::S_D1: if (mul_done) m_in = div_rem;
         ecc_psm_pkg::S_D2: if (mul_done) m_in = div_rem;
         ecc_psm_pkg::S_D3: m_in = fadd(m_ff, aa_ff, p_ff);
         ecc_psm_pkg::S_A1: m_in = fsub(vy_ff, uy_ff, p_ff);
         ecc_psm_pkg::S_LAM: if (mul_done) lam_in = div_rem;
         ecc_psm_pkg::S_L2: if (mul_done) m_in = div_rem;
         ecc_psm_pkg::S_X1: wx_in = fsub(m_ff, ux_ff, p_ff);
         ecc_psm_pkg::S_X2: wx_in = fsub(wx_ff, vx_ff, p_ff);
         ecc_psm_pkg::S_FX: m_in = fsub(ux_ff, wx_ff, p_ff);
         ecc_psm_pkg::S_G: if (mul_done) m_in = div_rem;
         ecc_psm_pkg::S_Y3: begin
            wy_in   = fsub(m_ff, uy_ff, p_ff);
            winf_in = 1'b0;
         end
         ecc_psm_pkg::S_OPEND: begin
            if (add_ph_ff) begin
               accx_in   = wx_ff;
               accy_in   = wy_ff;
               accinf_in = winf_ff;
            end else begin
               qx_in   = wx_ff;
               qy_in   = wy_ff;
               qinf_in = winf_ff;
            end
         end
         ecc_psm_pkg::S_ARD: if (!k_ff[i_ff] && (i_ff != '0)) i_in = i_ff - AW'(1);
         ecc_psm_pkg::S_ALOAD: begin
            if (rd_inf) begin
               accinf_in = accinf_ff;
            end else if (accinf_ff) begin
               accx_in   = rdx;
               accy_in   = rdy;
               accinf_in = 1'b0;
            end else begin
               ux_in  = rdx;
               uy_in  = rdy;
               dbl_in = (rdx == accx_ff) && (rdy == accy_ff);
               vx_in  = ((rdx == accx_ff) && (rdy == accy_ff)) ? rdx : accx_ff;
               vy_in  = accy_ff;
            end
         end
         ecc_psm_pkg::S_ANEXT: if (i_ff != '0) i_in = i_ff - AW'(1);
         default: i_in = i_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) term_mem[i_ff] <= {qinf_ff, qx_ff, qy_ff};
      rd_ff <= term_mem[i_ff];
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;       aa_ff <= aa_in;     k_ff <= k_in;       kd_ff <= kd_in;
      i_ff <= i_in;       add_ph_ff <= add_ph_in;                 dbl_ff <= dbl_in;
      qx_ff <= qx_in;     qy_ff <= qy_in;     qinf_ff <= qinf_in;
      accx_ff <= accx_in; accy_ff <= accy_in; accinf_ff <= accinf_in;
      ux_ff <= ux_in;     uy_ff <= uy_in;     vx_ff <= vx_in;     vy_ff <= vy_in;
      wx_ff <= wx_in;     wy_ff <= wy_in;     winf_ff <= winf_in;
      m_ff <= m_in;       lam_ff <= lam_in;   inv_ff <= inv_in;   prod_ff <= prod_in;
      rp_ff <= rp_in;     rc_ff <= rc_in;     tp_ff <= tp_in;     tc_ff <= tc_in;
      tq_ff <= tq_in;
      rx_ff <= rx_in;     ry_ff <= ry_in;     rinf_ff <= rinf_in;
      if (reset) begin
         state_ff     <= ecc_psm_pkg::S_IDLE;
         step_ff      <= ecc_psm_pkg::STEP_MUL;
         rsp_valid_ff <= 1'b0;
         pcfg_ff      <= ecc_psm_pkg::PRIME_RESET;
         acfg_ff      <= ecc_psm_pkg::CURVE_A_RESET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index == ecc_psm_pkg::CSR_PRIME_MODULUS)) pcfg_ff <= csr_wdata;
         if (csr_we && (csr_index == ecc_psm_pkg::CSR_CURVE_A)) acfg_ff <= csr_wdata;
      end
   end

   assign req_if.ready       = (state_ff == ecc_psm_pkg::S_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.result_x    = rx_ff;
   assign rsp_if.result_y    = ry_ff;
   assign rsp_if.at_infinity = rinf_ff;

   a_inf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rinf_ff) |-> ((rx_ff == '0) && (ry_ff == '0)))
      else $error("infinity result with non-zero coordinates");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ecc_psm_pkg::S_DONE))
      else $error("response raised outside completion");

   a_inv_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ecc_psm_pkg::S_EEND) && (rp_ff == FB'(1))) |=> (inv_ff < p_ff))
      else $error("inverse not reduced");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |=> !div_done)
      else $error("divider finished straight after start");
endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the elliptic-curve point multiplier: table-driven and random words.
// Depends on ecc_psm_pkg, ecc_psm_req_if, ecc_psm_rsp_if and ecc_point_scalar_multiply.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] x;
      logic [15:0] y;
      logic        inf;
   } point_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] k;
      logic        fixed;
      logic [15:0] ex;
      logic [15:0] ey;
      logic        einf;
   } stim_row_type;

   localparam int N_ROWS = 14;
   localparam int N_SETS = 9;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [ecc_psm_pkg::CSR_AW-1:0] csr_index = ecc_psm_pkg::CSR_PRIME_MODULUS;
   logic [ecc_psm_pkg::IO_BITS-1:0] csr_wdata = '0;
   logic quiet = 1'b0;
   int errors = 0;
   int stall_left = 0;
   longint unsigned field_p = 64'(ecc_psm_pkg::PRIME_RESET);
   longint unsigned field_a = 64'(ecc_psm_pkg::CURVE_A_RESET);
   point_type expected_points[$];

   ecc_psm_req_if req ();
   ecc_psm_rsp_if rsp ();

   ecc_point_scalar_multiply u_top (
      .clock(clock), .reset(reset), .req_if(req.sink), .rsp_if(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // modulus 97, curve_a 2 after reset
   stim_row_type steer[N_ROWS] = '{
      '{16'd5, 16'd1, 16'd0, 1'b1, 16'd0, 16'd0, 1'b1},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 16'd0, 1'b0},
      '{16'd0, 16'd0, 16'd0, 1'b1, 16'd0, 16'd0, 1'b1},
      '{16'd5, 16'd1, 16'd1, 1'b1, 16'd5, 16'd1, 1'b0},
      '{16'hFFFF, 16'hFFFF, 16'd1, 1'b1, 16'd60, 16'd60, 1'b0},
      '{16'd3, 16'd0, 16'd2, 1'b1, 16'd0, 16'd0, 1'b1},
      '{16'd3, 16'd97, 16'd2, 1'b1, 16'd0, 16'd0, 1'b1},
      '{16'd3, 16'd6, 16'd2, 1'b0, 16'd0, 16'd0, 1'b0},
      '{16'd3, 16'd6, 16'd3, 1'b0, 16'd0, 16'd0, 1'b0},
      '{16'd3, 16'd6, 16'd5, 1'b0, 16'd0, 16'd0, 1'b0},
      '{16'd17, 16'd10, 16'h8000, 1'b0, 16'd0, 16'd0, 1'b0},
      '{16'd17, 16'd10, 16'hAAAA, 1'b0, 16'd0, 16'd0, 1'b0},
      '{16'd80, 16'd10, 16'h5555, 1'b0, 16'd0, 16'd0, 1'b0},
      '{16'd96, 16'd45, 16'd100, 1'b0, 16'd0, 16'd0, 1'b0}
   };

   logic [15:0] set_p[N_SETS] = '{16'd65521, 16'd3, 16'd65535, 16'd4, 16'd0, 16'd1,
                                  16'd2, 16'd1009, 16'd97};
   logic [15:0] set_a[N_SETS] = '{16'hFFFF, 16'd0, 16'd1, 16'd3, 16'd5, 16'd0,
                                  16'd1, 16'd1008, 16'd2};

   function automatic bit field_inverse(longint unsigned v, longint unsigned p,
                                        output longint unsigned inv);
      longint unsigned r_prev, r_cur, q, r_next;
      longint t_prev, t_cur, t_next;
      r_prev = p;
      r_cur = v;
      t_prev = 0;
      t_cur = 1;
      inv = 0;
      while (r_cur != 0) begin
         q = r_prev / r_cur;
         r_next = r_prev % r_cur;
         t_next = t_prev - t_cur * longint'(q);
         r_prev = r_cur;
         r_cur = r_next;
         t_prev = t_cur;
         t_cur = t_next;
      end
      if (r_prev != 1) return 1'b0;
      if (t_prev < 0) t_prev += longint'(p);
      inv = longint'(t_prev) % p;
      return 1'b1;
   endfunction

   function automatic point_type point_double(point_type s, longint unsigned p,
                                              longint unsigned a);
      point_type r;
      longint unsigned inv, num, lam, x3, sx, sy;
      r = '{0, 0, 1'b1};
      sx = 64'(s.x);
      sy = 64'(s.y);
      if (s.inf) return r;
      if (!field_inverse((2 * sy) % p, p, inv)) return r;
      num = ((3 * ((sx * sx) % p)) % p + a) % p;
      lam = (num * inv) % p;
      x3 = ((lam * lam) % p + p - (2 * sx) % p) % p;
      r.x = 16'(x3);
      r.y = 16'((((lam * ((sx + p - x3) % p)) % p) + p - sy) % p);
      r.inf = 1'b0;
      return r;
   endfunction

   function automatic point_type point_add(point_type s, point_type t, longint unsigned p,
                                           longint unsigned a);
      point_type r;
      longint unsigned inv, lam, x3, sx, sy, tx, ty;
      r = '{0, 0, 1'b1};
      sx = 64'(s.x);
      sy = 64'(s.y);
      tx = 64'(t.x);
      ty = 64'(t.y);
      if (s.inf) return t;
      if (t.inf) return s;
      if (sx == tx && sy == ty) return point_double(s, p, a);
      if (!field_inverse((tx + p - sx) % p, p, inv)) return r;
      lam = (((ty + p - sy) % p) * inv) % p;
      x3 = (((lam * lam) % p + p - sx) % p + p - tx) % p;
      r.x = 16'(x3);
      r.y = 16'((((lam * ((sx + p - x3) % p)) % p) + p - sy) % p);
      r.inf = 1'b0;
      return r;
   endfunction

   function automatic point_type scalar_multiply(logic [15:0] bx, logic [15:0] by,
                                                 logic [15:0] k);
      point_type terms[ecc_psm_pkg::SCALAR_BITS];
      point_type acc;
      longint unsigned a;
      int top;
      acc = '{0, 0, 1'b1};
      top = -1;
      if (field_p >= 2 && k != 0) begin
         a = field_a % field_p;
         for (int i = 0; i < ecc_psm_pkg::SCALAR_BITS; i++)
            if (k[i]) top = i;
         terms[0].x = 16'(64'(bx) % field_p);
         terms[0].y = 16'(64'(by) % field_p);
         terms[0].inf = 1'b0;
         for (int i = 1; i <= top; i++)
            terms[i] = point_double(terms[i-1], field_p, a);
         acc = terms[top];
         for (int i = top - 1; i >= 0; i--)
            if (k[i]) acc = point_add(terms[i], acc, field_p, a);
      end
      if (acc.inf) acc = '{0, 0, 1'b1};
      return acc;
   endfunction

   task automatic report(string what, logic [15:0] got, logic [15:0] want);
      $display("%t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   task automatic send_word(logic [15:0] x, logic [15:0] y, logic [15:0] k,
                            bit fixed, point_type want);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.base_x <= x;
      req.base_y <= y;
      req.scalar_k <= k;
      do @(posedge clock); while (!req.ready);
      expected_points.push_back(fixed ? want : scalar_multiply(x, y, k));
   endtask

   task automatic send_random(int n);
      logic [15:0] x, y, k;
      point_type none;
      none = '{0, 0, 1'b1};
      for (int i = 0; i < n; i++) begin
         if (field_p > 1 && $urandom_range(0, 4) != 0) begin
            x = 16'($urandom_range(0, int'(field_p) - 1));
            y = 16'($urandom_range(0, int'(field_p) - 1));
         end else begin
            x = 16'($urandom);
            y = 16'($urandom);
         end
         case ($urandom_range(0, 9))
            0: k = 16'd0;
            1, 2: k = 16'($urandom);
            3: k = 16'hFFFF;
            default: k = 16'($urandom_range(1, 255));
         endcase
         send_word(x, y, k, 1'b0, none);
      end
   endtask

   task automatic drain;
      req.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_points.size() == 0) begin
            report("unexpected word", rsp.result_x, 16'd0);
         end else begin
            want = expected_points.pop_front();
            if (rsp.result_x !== want.x) report("result_x", rsp.result_x, want.x);
            if (rsp.result_y !== want.y) report("result_y", rsp.result_y, want.y);
            if (rsp.at_infinity !== want.inf)
               report("at_infinity", 16'(rsp.at_infinity), 16'(want.inf));
         end
      end
   end

   // response back-pressure in bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp.ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp.ready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   initial begin
      point_type want;
      req.valid = 1'b0;
      req.base_x = '0;
      req.base_y = '0;
      req.scalar_k = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int r = 0; r < N_ROWS; r++) begin
         want = '{steer[r].ex, steer[r].ey, steer[r].einf};
         send_word(steer[r].x, steer[r].y, steer[r].k, steer[r].fixed, want);
      end
      send_random(10);
      drain();
      for (int s = 0; s < N_SETS; s++) begin
         csr_we <= 1'b1;
         csr_index <= ecc_psm_pkg::CSR_PRIME_MODULUS;
         csr_wdata <= set_p[s];
         @(posedge clock);
         csr_index <= ecc_psm_pkg::CSR_CURVE_A;
         csr_wdata <= set_a[s];
         @(posedge clock);
         csr_we <= 1'b0;
         field_p = 64'(set_p[s]);
         field_a = 64'(set_a[s]);
         if (s == N_SETS - 1) quiet <= 1'b1;
         send_random(s == N_SETS - 1 ? 20 : 12);
         drain();
      end
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("*** FAILED ***");
      $finish;
   end
endmodule

// ===== sim.f =====
sv/ecc_psm_pkg.sv
sv/ecc_psm_req_if.sv
sv/ecc_psm_rsp_if.sv
sv/ecc_psm_div.sv
sv/ecc_point_scalar_multiply.sv
tb/testbench.sv
